@@ src/gadc_pkg.sv @@
// ----------------------------------------------------------------------------
// gadc_pkg
// Shared types, constants and helper functions of the axis deadzone
// conditioner.
// ----------------------------------------------------------------------------
package gadc_pkg;

   localparam int PAD_COUNT = 4;

   localparam int LANES   = 6;
   localparam int LANE_LT = 0;
   localparam int LANE_RT = 1;
   localparam int LANE_LX = 2;
   localparam int LANE_LY = 3;
   localparam int LANE_RX = 4;
   localparam int LANE_RY = 5;

   localparam int DIV_STEPS       = 15;
   localparam int STEPS_PER_STAGE = 3;
   localparam int DIV_STAGES      = DIV_STEPS / STEPS_PER_STAGE;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [14:0] Q_MAX = 15'h7fff;

   localparam logic [2:0] CSR_PAD_ENABLE     = 3'd0;
   localparam logic [2:0] CSR_SCALE_LOW      = 3'd1;
   localparam logic [2:0] CSR_SCALE_HIGH     = 3'd2;
   localparam logic [2:0] CSR_STICK_LEVEL    = 3'd3;
   localparam logic [2:0] CSR_TRIGGER_LEVEL  = 3'd4;
   localparam logic [2:0] CSR_TRIGGER_FLOOR  = 3'd5;
   localparam logic [2:0] CSR_LEFT_DEADZONE  = 3'd6;
   localparam logic [2:0] CSR_RIGHT_DEADZONE = 3'd7;

   typedef struct packed {
      logic        zero;
      logic        sat;
      logic        neg;
      logic [14:0] diff;
   } lane_in_type;

   typedef struct packed {
      logic [1:0]                   pad_id;
      logic                         active;
      logic [15:0]                  buttons;
      lane_in_type [LANES-1:0]      lanes;
   } front_item_type;

   typedef struct packed {
      logic        zero;
      logic        sat;
      logic        neg;
      logic [14:0] rem;
      logic [14:0] quo;
   } lane_work_type;

   typedef struct packed {
      logic [1:0]                   pad_id;
      logic                         active;
      logic [15:0]                  buttons;
      lane_work_type [LANES-1:0]    lanes;
   } back_item_type;

   // magnitude 0..32768 against the remap window
   function automatic lane_in_type classify(logic [15:0] m, logic [14:0] low,
                                            logic [14:0] high);
      lane_in_type r;
      r.zero = (m == 16'd0) || (m <= {1'b0, low});
      r.sat  = !r.zero && ((high <= low) || (m >= {1'b0, high}));
      r.neg  = 1'b0;
      r.diff = m[14:0] - low;
      return r;
   endfunction

   // one restoring division step
   function automatic lane_work_type div_step(lane_work_type w, logic b,
                                              logic [14:0] d);
      lane_work_type r;
      logic [15:0]   t;
      r = w;
      t = {w.rem, b};
      if (t >= {1'b0, d}) begin
         r.rem = 15'(t - {1'b0, d});
         r.quo = {w.quo[13:0], 1'b1};
      end else begin
         r.rem = t[14:0];
         r.quo = {w.quo[13:0], 1'b0};
      end
      return r;
   endfunction

endpackage

@@ src/gadc_front.sv @@
// ----------------------------------------------------------------------------
// gadc_front
// Accepts raw reports, applies floors and deadzones, normalizes magnitudes
// and classifies each value against the remap window.
// ----------------------------------------------------------------------------
module gadc_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_pad_index,
   input  logic                    req_connected,
   input  logic [15:0]             req_raw_buttons,
   input  logic [7:0]              req_raw_left_trigger,
   input  logic [7:0]              req_raw_right_trigger,
   input  logic signed [15:0]      req_raw_left_x,
   input  logic signed [15:0]      req_raw_left_y,
   input  logic signed [15:0]      req_raw_right_x,
   input  logic signed [15:0]      req_raw_right_y,
   input  logic                    pad_enable,
   input  logic [14:0]             scale_low,
   input  logic [14:0]             scale_high,
   input  logic [7:0]              trigger_raw_floor,
   input  logic [14:0]             left_raw_deadzone,
   input  logic [14:0]             right_raw_deadzone,
   output logic                    out_valid,
   input  logic                    out_ready,
   output gadc_pkg::front_item_type out_item
);
   import gadc_pkg::*;

   logic           valid_ff;
   front_item_type item_ff;
   front_item_type item_in;
   logic           act;

   function automatic lane_in_type do_trigger(logic [7:0] t, logic [7:0] floor_v,
                                              logic [14:0] low, logic [14:0] high);
      logic [15:0] x;
      logic [15:0] frac;
      logic [15:0] m;
      lane_in_type r;
      x    = {1'b0, t, 7'h7f};
      frac = 16'((17'(x) + 17'd1 + 17'(x[15:8])) >> 8);
      m    = 16'({t, 7'd0}) + frac;
      r    = classify(m, low, high);
      if (t <= floor_v) begin
         r.zero = 1'b1;
         r.sat  = 1'b0;
      end
      return r;
   endfunction

   function automatic lane_in_type do_axis(logic signed [15:0] x, logic [14:0] dz,
                                           logic [14:0] low, logic [14:0] high);
      logic signed [16:0] xs;
      logic [15:0]        m;
      lane_in_type        r;
      xs = 17'(x);
      if (x[15]) begin
         m = 16'(-xs);
      end else begin
         m = 16'(x) + 16'(x[14]);
      end
      r     = classify(m, low, high);
      r.neg = x[15];
      if ((xs <= $signed({2'b00, dz})) && (xs >= -$signed({2'b00, dz}))) begin
         r.zero = 1'b1;
         r.sat  = 1'b0;
      end
      return r;
   endfunction

   always_comb begin
      act = pad_enable && req_connected && (32'(req_pad_index) < PAD_COUNT);
      item_in.pad_id  = req_pad_index;
      item_in.active  = act;
      item_in.buttons = act ? req_raw_buttons : 16'd0;
      item_in.lanes[LANE_LT] = do_trigger(req_raw_left_trigger, trigger_raw_floor,
                                          scale_low, scale_high);
      item_in.lanes[LANE_RT] = do_trigger(req_raw_right_trigger, trigger_raw_floor,
                                          scale_low, scale_high);
      item_in.lanes[LANE_LX] = do_axis(req_raw_left_x, left_raw_deadzone,
                                       scale_low, scale_high);
      item_in.lanes[LANE_LY] = do_axis(req_raw_left_y, left_raw_deadzone,
                                       scale_low, scale_high);
      item_in.lanes[LANE_RX] = do_axis(req_raw_right_x, right_raw_deadzone,
                                       scale_low, scale_high);
      item_in.lanes[LANE_RY] = do_axis(req_raw_right_y, right_raw_deadzone,
                                       scale_low, scale_high);
      if (!act) begin
         for (int i = 0; i < LANES; i++) begin
            item_in.lanes[i].zero = 1'b1;
            item_in.lanes[i].sat  = 1'b0;
         end
      end
   end

   assign req_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ src/gadc_queue.sv @@
// ----------------------------------------------------------------------------
// gadc_queue
// Short FIFO between the classifying front and the dividing back.
// ----------------------------------------------------------------------------
module gadc_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  gadc_pkg::front_item_type in_item,
   output logic                     out_valid,
   input  logic                     out_ready,
   output gadc_pkg::front_item_type out_item
);
   import gadc_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   front_item_type             mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]              wr_ptr_ff;
   logic [PW-1:0]              rd_ptr_ff;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] count_ff;
   logic                       push;
   logic                       pop;

   assign in_ready  = 32'(count_ff) < QUEUE_DEPTH;
   assign out_valid = count_ff != '0;
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : PW'(wr_ptr_ff + 1'b1);
         end
         if (pop) begin
            rd_ptr_ff <= (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : PW'(rd_ptr_ff + 1'b1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= QUEUE_DEPTH) else $error("queue count overflow");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count lost a push");
   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count lost a pop");

endmodule

@@ src/gadc_back.sv @@
// ----------------------------------------------------------------------------
// gadc_back
// Pipelined remap division for all six values, sign restore, derived
// presses and the result register.
// ----------------------------------------------------------------------------
module gadc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  gadc_pkg::front_item_type in_item,
   input  logic [14:0]              scale_low,
   input  logic [14:0]              scale_high,
   input  logic [14:0]              stick_press_level,
   input  logic [14:0]              trigger_press_level,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_pad_id,
   output logic                     rsp_active,
   output logic [15:0]              rsp_buttons_out,
   output logic [14:0]              rsp_left_trigger,
   output logic [14:0]              rsp_right_trigger,
   output logic signed [15:0]       rsp_left_x,
   output logic signed [15:0]       rsp_left_y,
   output logic signed [15:0]       rsp_right_x,
   output logic signed [15:0]       rsp_right_y,
   output logic [5:0]               rsp_derived_presses,
   output logic                     rsp_any_input
);
   import gadc_pkg::*;

   back_item_type        stg_ff [DIV_STAGES];
   back_item_type        stg_in [DIV_STAGES];
   logic [DIV_STAGES-1:0] vld_ff;
   logic                 en;
   logic [14:0]          d;
   logic [14:0]          half_d;
   back_item_type        init;
   back_item_type        last;
   logic [14:0]          r [LANES];
   logic                 rsp_valid_ff;

   assign en       = !rsp_valid_ff || rsp_ready;
   assign in_ready = en;
   assign d        = scale_high - scale_low;
   assign half_d   = d >> 1;
   assign last     = stg_ff[DIV_STAGES-1];
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      init.pad_id  = in_item.pad_id;
      init.active  = in_item.active;
      init.buttons = in_item.buttons;
      for (int i = 0; i < LANES; i++) begin
         init.lanes[i].zero = in_item.lanes[i].zero;
         init.lanes[i].sat  = in_item.lanes[i].sat;
         init.lanes[i].neg  = in_item.lanes[i].neg;
         init.lanes[i].rem  = in_item.lanes[i].diff;
         init.lanes[i].quo  = '0;
      end
   end

   always_comb begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         stg_in[s] = (s == 0) ? init : stg_ff[(s == 0) ? 0 : s - 1];
         for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            for (int i = 0; i < LANES; i++) begin
               stg_in[s].lanes[i] = div_step(stg_in[s].lanes[i],
                  half_d[4'(DIV_STEPS - 1 - (s * STEPS_PER_STAGE + j))], d);
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         priority if (last.lanes[i].zero) begin
            r[i] = '0;
         end else if (last.lanes[i].sat) begin
            r[i] = Q_MAX;
         end else begin
            r[i] = last.lanes[i].quo;
         end
      end
   end

   function automatic logic signed [15:0] signed_out(logic [14:0] v, logic neg);
      return neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[DIV_STAGES-2:0], in_valid};
         rsp_valid_ff <= vld_ff[DIV_STAGES-1];
      end
      if (en) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            stg_ff[s] <= stg_in[s];
         end
         rsp_pad_id        <= last.pad_id;
         rsp_active        <= last.active;
         rsp_buttons_out   <= last.buttons;
         rsp_left_trigger  <= r[LANE_LT];
         rsp_right_trigger <= r[LANE_RT];
         rsp_left_x        <= signed_out(r[LANE_LX], last.lanes[LANE_LX].neg);
         rsp_left_y        <= signed_out(r[LANE_LY], last.lanes[LANE_LY].neg);
         rsp_right_x       <= signed_out(r[LANE_RX], last.lanes[LANE_RX].neg);
         rsp_right_y       <= signed_out(r[LANE_RY], last.lanes[LANE_RY].neg);
         rsp_derived_presses <= {
            r[LANE_RT] > trigger_press_level,
            r[LANE_LT] > trigger_press_level,
            last.lanes[LANE_LX].neg && (r[LANE_LX] > stick_press_level),
            !last.lanes[LANE_LX].neg && (r[LANE_LX] > stick_press_level),
            last.lanes[LANE_LY].neg && (r[LANE_LY] > stick_press_level),
            !last.lanes[LANE_LY].neg && (r[LANE_LY] > stick_press_level)};
         rsp_any_input <= (last.buttons != 16'd0) || (r[LANE_LT] != '0) ||
                          (r[LANE_RT] != '0) || (r[LANE_LX] != '0) ||
                          (r[LANE_LY] != '0) || (r[LANE_RX] != '0) ||
                          (r[LANE_RY] != '0);
      end
   end

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> (vld_ff == $past(vld_ff))) else $error("pipeline moved while stalled");
   a_idle_inactive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_active) |-> (rsp_any_input == 1'b0 &&
      rsp_derived_presses == 6'd0)) else $error("inactive pad reports input");
   a_feed: assert property (@(posedge clock) disable iff (reset)
      (en && vld_ff[DIV_STAGES-1]) |=> rsp_valid_ff) else $error("result dropped");

endmodule

@@ src/gamepad_axis_deadzone_conditioner.sv @@
// ----------------------------------------------------------------------------
// gamepad_axis_deadzone_conditioner
// Turns raw gamepad reports into deadzone-filtered, remapped Q1.15 values
// with derived stick and trigger presses.
// ----------------------------------------------------------------------------
// Each report passes through the front register, the queue, five stages of the
// shared-form remap divider at three quotient bits each and the result register;
// throughput is one report per cycle while rsp_ready stays high. Registers may be
// written only while no report is in flight.
module gamepad_axis_deadzone_conditioner (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [14:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_pad_index,
   input  logic               req_connected,
   input  logic [15:0]        req_raw_buttons,
   input  logic [7:0]         req_raw_left_trigger,
   input  logic [7:0]         req_raw_right_trigger,
   input  logic signed [15:0] req_raw_left_x,
   input  logic signed [15:0] req_raw_left_y,
   input  logic signed [15:0] req_raw_right_x,
   input  logic signed [15:0] req_raw_right_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_pad_id,
   output logic               rsp_active,
   output logic [15:0]        rsp_buttons_out,
   output logic [14:0]        rsp_left_trigger,
   output logic [14:0]        rsp_right_trigger,
   output logic signed [15:0] rsp_left_x,
   output logic signed [15:0] rsp_left_y,
   output logic signed [15:0] rsp_right_x,
   output logic signed [15:0] rsp_right_y,
   output logic [5:0]         rsp_derived_presses,
   output logic               rsp_any_input
);
   import gadc_pkg::*;

   logic           pad_enable_ff;
   logic [14:0]    scale_low_ff;
   logic [14:0]    scale_high_ff;
   logic [14:0]    stick_level_ff;
   logic [14:0]    trigger_level_ff;
   logic [7:0]     trigger_floor_ff;
   logic [14:0]    left_dz_ff;
   logic [14:0]    right_dz_ff;

   logic           f_valid;
   logic           f_ready;
   front_item_type f_item;
   logic           q_valid;
   logic           q_ready;
   front_item_type q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_enable_ff    <= 1'b1;
         scale_low_ff     <= 15'd9830;
         scale_high_ff    <= 15'd24576;
         stick_level_ff   <= 15'd22938;
         trigger_level_ff <= 15'd3277;
         trigger_floor_ff <= 8'd30;
         left_dz_ff       <= 15'd7849;
         right_dz_ff      <= 15'd8689;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PAD_ENABLE:     pad_enable_ff    <= csr_wdata[0];
            CSR_SCALE_LOW:      scale_low_ff     <= csr_wdata;
            CSR_SCALE_HIGH:     scale_high_ff    <= csr_wdata;
            CSR_STICK_LEVEL:    stick_level_ff   <= csr_wdata;
            CSR_TRIGGER_LEVEL:  trigger_level_ff <= csr_wdata;
            CSR_TRIGGER_FLOOR:  trigger_floor_ff <= csr_wdata[7:0];
            CSR_LEFT_DEADZONE:  left_dz_ff       <= csr_wdata;
            CSR_RIGHT_DEADZONE: right_dz_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   gadc_front u_front (
      .clock, .reset,
      .req_valid, .req_ready, .req_pad_index, .req_connected, .req_raw_buttons,
      .req_raw_left_trigger, .req_raw_right_trigger,
      .req_raw_left_x, .req_raw_left_y, .req_raw_right_x, .req_raw_right_y,
      .pad_enable         (pad_enable_ff),
      .scale_low          (scale_low_ff),
      .scale_high         (scale_high_ff),
      .trigger_raw_floor  (trigger_floor_ff),
      .left_raw_deadzone  (left_dz_ff),
      .right_raw_deadzone (right_dz_ff),
      .out_valid          (f_valid),
      .out_ready          (f_ready),
      .out_item           (f_item)
   );

   gadc_queue u_queue (
      .clock, .reset,
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_item   (f_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   gadc_back u_back (
      .clock, .reset,
      .in_valid            (q_valid),
      .in_ready            (q_ready),
      .in_item             (q_item),
      .scale_low           (scale_low_ff),
      .scale_high          (scale_high_ff),
      .stick_press_level   (stick_level_ff),
      .trigger_press_level (trigger_level_ff),
      .rsp_valid, .rsp_ready, .rsp_pad_id, .rsp_active, .rsp_buttons_out,
      .rsp_left_trigger, .rsp_right_trigger,
      .rsp_left_x, .rsp_left_y, .rsp_right_x, .rsp_right_y,
      .rsp_derived_presses, .rsp_any_input
   );

endmodule

@@ sim/gadc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gadc_checker
// Watches the report and result channels of the axis deadzone conditioner,
// predicts each conditioned report from a local copy of the registers and
// compares every result field by field, in order.
// ----------------------------------------------------------------------------
module gadc_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [14:0]        csr_wdata,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_pad_index,
   input  logic               req_connected,
   input  logic [15:0]        req_raw_buttons,
   input  logic [7:0]         req_raw_left_trigger,
   input  logic [7:0]         req_raw_right_trigger,
   input  logic signed [15:0] req_raw_left_x,
   input  logic signed [15:0] req_raw_left_y,
   input  logic signed [15:0] req_raw_right_x,
   input  logic signed [15:0] req_raw_right_y,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [1:0]         rsp_pad_id,
   input  logic               rsp_active,
   input  logic [15:0]        rsp_buttons_out,
   input  logic [14:0]        rsp_left_trigger,
   input  logic [14:0]        rsp_right_trigger,
   input  logic signed [15:0] rsp_left_x,
   input  logic signed [15:0] rsp_left_y,
   input  logic signed [15:0] rsp_right_x,
   input  logic signed [15:0] rsp_right_y,
   input  logic [5:0]         rsp_derived_presses,
   input  logic               rsp_any_input,
   output int                 fail_count,
   output int                 pending,
   output int                 result_count
);
   import gadc_pkg::*;

   typedef struct packed {
      logic [1:0]         pad_id;
      logic               active;
      logic [15:0]        buttons;
      logic [14:0]        lt;
      logic [14:0]        rt;
      logic signed [15:0] lx;
      logic signed [15:0] ly;
      logic signed [15:0] rx;
      logic signed [15:0] ry;
      logic [5:0]         presses;
      logic               any;
   } report_type;

   report_type expected_reports[$];

   logic        enable_r;
   logic [14:0] low_r, high_r, stick_lvl_r, trig_lvl_r, ldz_r, rdz_r;
   logic [7:0]  floor_r;

   function automatic logic [14:0] window(logic [31:0] m);
      logic [31:0] d;
      logic [31:0] r;
      if (m == 0 || m <= low_r) return 15'd0;
      if (high_r <= low_r || m >= high_r) return Q_MAX;
      d = high_r - low_r;
      r = ((m - low_r) * 32768 + d / 2) / d;
      return (r > 32767) ? Q_MAX : r[14:0];
   endfunction

   function automatic logic signed [15:0] stick(logic signed [15:0] x, logic [14:0] dz);
      int v;
      logic [31:0] m;
      v = x;
      if (v <= int'(dz) && v >= -int'(dz)) return 16'sd0;
      if (v > 0) begin
         m = (v * 32768 + 16383) / 32767;
         return $signed({1'b0, window(m)});
      end
      m = -v;
      return -$signed({1'b0, window(m)});
   endfunction

   function automatic logic [14:0] pull(logic [7:0] t);
      if (t <= floor_r) return 15'd0;
      return window((32'(t) * 32768 + 127) / 255);
   endfunction

   function automatic report_type condition_report();
      report_type e;
      int lvl;
      e = '0;
      e.pad_id = req_pad_index;
      if (!(enable_r && req_connected && int'(req_pad_index) < PAD_COUNT)) return e;
      e.active  = 1'b1;
      e.buttons = req_raw_buttons;
      e.lt = pull(req_raw_left_trigger);
      e.rt = pull(req_raw_right_trigger);
      e.lx = stick(req_raw_left_x, ldz_r);
      e.ly = stick(req_raw_left_y, ldz_r);
      e.rx = stick(req_raw_right_x, rdz_r);
      e.ry = stick(req_raw_right_y, rdz_r);
      lvl = stick_lvl_r;
      e.presses[0] = int'(e.ly) > lvl;
      e.presses[1] = int'(e.ly) < -lvl;
      e.presses[2] = int'(e.lx) > lvl;
      e.presses[3] = int'(e.lx) < -lvl;
      e.presses[4] = e.lt > trig_lvl_r;
      e.presses[5] = e.rt > trig_lvl_r;
      e.any = (e.buttons != 0) || (e.lt != 0) || (e.rt != 0) || (e.lx != 0) ||
              (e.ly != 0) || (e.rx != 0) || (e.ry != 0);
      return e;
   endfunction

   report_type got;
   assign got = '{rsp_pad_id, rsp_active, rsp_buttons_out, rsp_left_trigger,
                  rsp_right_trigger, rsp_left_x, rsp_left_y, rsp_right_x,
                  rsp_right_y, rsp_derived_presses, rsp_any_input};

   always @(posedge clock) begin
      report_type e;
      if (reset) begin
         enable_r <= 1'b1;
         low_r <= 15'd9830;
         high_r <= 15'd24576;
         stick_lvl_r <= 15'd22938;
         trig_lvl_r <= 15'd3277;
         floor_r <= 8'd30;
         ldz_r <= 15'd7849;
         rdz_r <= 15'd8689;
         fail_count <= 0;
         result_count <= 0;
         pending <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PAD_ENABLE:     enable_r <= csr_wdata[0];
               CSR_SCALE_LOW:      low_r <= csr_wdata;
               CSR_SCALE_HIGH:     high_r <= csr_wdata;
               CSR_STICK_LEVEL:    stick_lvl_r <= csr_wdata;
               CSR_TRIGGER_LEVEL:  trig_lvl_r <= csr_wdata;
               CSR_TRIGGER_FLOOR:  floor_r <= csr_wdata[7:0];
               CSR_LEFT_DEADZONE:  ldz_r <= csr_wdata;
               CSR_RIGHT_DEADZONE: rdz_r <= csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_reports.insert(expected_reports.size(), condition_report());
         end
         if (rsp_valid && rsp_ready) begin
            result_count <= result_count + 1;
            if (expected_reports.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected transaction %p", got);
            end else begin
               e = expected_reports.pop_front();
               if (got !== e) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10) $display("mismatch: exp %p got %p", e, got);
               end
            end
         end
         pending <= expected_reports.size();
      end
   end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the axis deadzone conditioner: directed corner
// reports, then random reports under several register settings, with random
// idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   import gadc_pkg::*;

   localparam int LIMIT = 200000;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [2:0] csr_index = CSR_PAD_ENABLE;
   logic [14:0] csr_wdata = 0;
   logic req_valid = 0, req_ready;
   logic [1:0] req_pad_index = 0;
   logic req_connected = 0;
   logic [15:0] req_raw_buttons = 0;
   logic [7:0] req_raw_left_trigger = 0, req_raw_right_trigger = 0;
   logic signed [15:0] req_raw_left_x = 0, req_raw_left_y = 0;
   logic signed [15:0] req_raw_right_x = 0, req_raw_right_y = 0;
   logic rsp_valid, rsp_ready = 0;
   logic [1:0] rsp_pad_id;
   logic rsp_active, rsp_any_input;
   logic [15:0] rsp_buttons_out;
   logic [14:0] rsp_left_trigger, rsp_right_trigger;
   logic signed [15:0] rsp_left_x, rsp_left_y, rsp_right_x, rsp_right_y;
   logic [5:0] rsp_derived_presses;
   int fail_count, pending, result_count;
   int cycles = 0;
   bit calm = 0;

   always #5 clock = ~clock;

   gamepad_axis_deadzone_conditioner dut (.*);
   gadc_checker checker_i (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 17);
      if (cycles > LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic logic signed [15:0] rand_axis();
      case ($urandom_range(5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'(int'($urandom_range(9000)) - 4500);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_report(logic [1:0] idx, logic con, logic [15:0] btn, logic [7:0] lt,
                              logic [7:0] rt, logic signed [15:0] lx, logic signed [15:0] ly,
                              logic signed [15:0] rx, logic signed [15:0] ry);
      while (!calm && $urandom_range(99) < 17) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1; req_pad_index <= idx; req_connected <= con;
      req_raw_buttons <= btn; req_raw_left_trigger <= lt; req_raw_right_trigger <= rt;
      req_raw_left_x <= lx; req_raw_left_y <= ly; req_raw_right_x <= rx; req_raw_right_y <= ry;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   task automatic send_random(int n);
      repeat (n)
         send_report(2'($urandom), $urandom_range(9) != 0,
                     ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom),
                     8'($urandom), 8'($urandom), rand_axis(), rand_axis(), rand_axis(),
                     rand_axis());
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [14:0] val);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic write_all(logic en, logic [14:0] lo, logic [14:0] hi, logic [14:0] sl,
                            logic [14:0] tl, logic [7:0] fl, logic [14:0] ld, logic [14:0] rd);
      drain();
      write_reg(CSR_PAD_ENABLE, 15'(en));
      write_reg(CSR_SCALE_LOW, lo);
      write_reg(CSR_SCALE_HIGH, hi);
      write_reg(CSR_STICK_LEVEL, sl);
      write_reg(CSR_TRIGGER_LEVEL, tl);
      write_reg(CSR_TRIGGER_FLOOR, 15'(fl));
      write_reg(CSR_LEFT_DEADZONE, ld);
      write_reg(CSR_RIGHT_DEADZONE, rd);
      csr_we <= 0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // deadzone edges, extremes, inactive cases
      send_report(2'd0, 1'b1, 16'hffff, 8'd255, 8'd0, 16'sd7849, -16'sd7849, 16'sd8689,
                  -16'sd8689);
      send_report(2'd1, 1'b1, 16'd0, 8'd30, 8'd31, 16'sd7850, -16'sd7850, 16'sd8690,
                  -16'sd8690);
      send_report(2'd2, 1'b1, 16'd0, 8'd0, 8'd0, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
      send_report(2'd3, 1'b1, 16'h5555, 8'd200, 8'd255, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_report(2'd3, 1'b0, 16'haaaa, 8'd255, 8'd255, 16'sh7fff, 16'sh8000, 16'sd1, -16'sd1);
      send_report(2'd2, 1'b1, 16'h0001, 8'd128, 8'd64, 16'sd20000, -16'sd20000, 16'sd30000,
                  -16'sd30000);
      send_report(2'd1, 1'b1, 16'd0, 8'd0, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_random(100);
      // pause until everything is back
      drain();
      calm = 1;
      send_random(100);
      calm = 0;
      write_all(1'b1, 15'd0, 15'h7fff, 15'd0, 15'd0, 8'd0, 15'd0, 15'd0);
      send_report(2'd0, 1'b1, 16'd0, 8'd1, 8'd255, 16'sd1, -16'sd1, 16'sh8000, 16'sh7fff);
      send_random(100);
      // inverted window gives a step
      write_all(1'b1, 15'h7fff, 15'd1, 15'h7fff, 15'h7fff, 8'd255, 15'h7fff, 15'h7fff);
      send_random(60);
      write_all(1'b1, 15'd20000, 15'd20000, 15'd1000, 15'd100, 8'd0, 15'd100, 15'd200);
      send_random(100);
      write_all(1'b0, 15'd100, 15'd30000, 15'd10000, 15'd10000, 8'd10, 15'd1000, 15'd1000);
      send_random(40);
      write_all(1'b1, 15'd16000, 15'd16001, 15'd16000, 15'd1, 8'd128, 15'd16383, 15'd4096);
      send_random(100);
      write_all(1'b1, 15'd9830, 15'd24576, 15'd22938, 15'd3277, 8'd30, 15'd7849, 15'd8689);
      send_random(100);
      drain();
      $display("covered %0d results over six register settings, incl. inverted window",
               result_count);
      $display("and disabled pad, deadzone edges and full-scale axes");
      if (fail_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
